@@ rtl/ir90_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ir90_pkg;

  // Field widths
  localparam int DIM_W   = 11;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int ST_W    = 2;
  localparam int CFG_I_W = 2;

  // Default sizes
  localparam int DEF_MAX_PIXELS = 65536;
  localparam int DEF_MAX_DIM    = 1024;

  // Opcodes carried on in_tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Status codes carried on out_tuser
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [ST_W-1:0] ST_LOAD_PAST = 2'd2;
  localparam logic [ST_W-1:0] ST_EARLY     = 2'd3;

  // Register indexes
  localparam logic [CFG_I_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_I_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_I_W-1:0] REG_RGB    = 2'd2;
  localparam logic [CFG_I_W-1:0] REG_DIR    = 2'd3;

  // Direction codes
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

endpackage

`default_nettype wire

@@ rtl/ir90_frame_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ir90_frame_store #(
  parameter int DEPTH = ir90_pkg::DEF_MAX_PIXELS,
  parameter int AW    = 16
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [ir90_pkg::PIX_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [ir90_pkg::PIX_W-1:0] rd_data
);
  import ir90_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/ir90_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module ir90_divider #(
  parameter int CW = 17
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [CW-1:0]             dividend,
  input  wire logic [ir90_pkg::DIM_W-1:0] divisor,
  output logic                           done,
  output logic      [CW-1:0]             quot,
  output logic      [ir90_pkg::DIM_W-1:0] rem
);
  import ir90_pkg::*;

  localparam int CNT_W = $clog2(CW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CW-1:0]    q_r;
  logic [DIM_W-1:0] rem_r;
  logic [DIM_W-1:0] div_r;

  logic [DIM_W:0]   trial;
  logic [DIM_W:0]   diff;
  logic             ge;

  // One trial subtraction
  assign trial = {rem_r, q_r[CW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(CW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= (q_r << 1) | CW'(ge);
      rem_r <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

@@ rtl/image_rotate_90.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Frame rotation engine. Load beats (in_tuser = 0) write source pixels in
// row-major order into an on-chip frame store of MAX_PIXELS 24-bit entries;
// once width*height pixels are in, drain beats (in_tuser = 1) return the
// image rotated 90 degrees (cfg direction 0 clockwise, 1 counter-clockwise),
// one pixel per beat, with out_tlast on the final pixel, after which the
// engine is ready for the next frame. Every input beat yields exactly one
// output beat; out_tuser carries the status. Loads can stream at one per
// clock while the result stream is not stalled. A drain beat passes through
// the row-offset multiply, then the address add and the frame store read,
// then the read data, held until the result stream has room. After any
// register write the engine recomputes the frame size before it takes the
// next beat, with a serial divide by the height when the drain position
// lies inside the frame. A register write during the recompute restarts
// it. Write registers only while no beat is in flight. The frame store is
// not cleared at reset.
module image_rotate_90 #(
  parameter int MAX_PIXELS = ir90_pkg::DEF_MAX_PIXELS,
  parameter int MAX_DIM    = ir90_pkg::DEF_MAX_DIM
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input stream
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [ir90_pkg::PIX_W-1:0]  in_tdata,  // channel_0, channel_1, channel_2
  input  wire logic                        in_tuser,  // opcode
  // result stream
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [ir90_pkg::PIX_W-1:0]  out_tdata, // out_channel_0, _1, _2
  output logic      [ir90_pkg::ST_W-1:0]   out_tuser, // status
  output logic                             out_tlast,
  // register writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ir90_pkg::CFG_I_W-1:0] cfg_index,
  input  wire logic [ir90_pkg::DIM_W-1:0]  cfg_data
);
  import ir90_pkg::*;

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int PW = 2 * DIM_W;

  // States
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADDR  = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_SIZE  = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic             dirty_r, dirty_nxt;
  logic [DIM_W-1:0] w_r, h_r;
  logic             rgb_r, dir_r;
  logic [CW-1:0]    total_r, total_nxt;
  logic             valid_r, valid_nxt;
  logic [CW-1:0]    load_cnt_r, load_cnt_nxt;
  logic [CW-1:0]    drain_cnt_r, drain_cnt_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [PW-1:0]    prod_r;
  logic [DIM_W-1:0] off_r;
  logic             last_r;
  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;
  logic [PIX_W-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_fire, cfg_fire, out_free, is_load;
  logic             load_full, load_ok, drain_ok;
  logic [CW-1:0]    k_eff, k_inc;
  logic             last_now;
  logic [DIM_W-1:0] fac, off, col_inc;
  logic [PW-1:0]    mul_prod, size_prod, addr_sum;
  logic             size_ok;
  logic             div_start, div_done;
  logic [CW-1:0]    div_quot;
  logic [DIM_W-1:0] div_rem;
  logic             mem_rd_en;
  logic [PIX_W-1:0] mem_wr_data, mem_rd_data, drain_pix;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign out_free  = ~out_valid_r | out_tready;
  assign in_tready = (state_r == S_IDLE) & ~dirty_r & out_free;
  assign in_fire   = in_tvalid & in_tready;
  assign is_load   = (in_tuser == OP_LOAD);

  // Frame progress
  assign load_full = load_cnt_r >= total_r;
  assign load_ok   = in_fire & valid_r & is_load & ~load_full;
  assign drain_ok  = in_fire & valid_r & ~is_load & load_full;
  assign k_eff     = (drain_cnt_r >= total_r) ? '0 : drain_cnt_r;
  assign k_inc     = k_eff + CW'(1);
  assign last_now  = k_inc >= total_r;
  assign col_inc   = col_r + DIM_W'(1);

  // Source position of the next rotated pixel: row offset times width
  assign fac      = (dir_r == DIR_CCW) ? col_r : (h_r - col_r - DIM_W'(1));
  assign off      = (dir_r == DIR_CCW) ? (w_r - row_r - DIM_W'(1)) : row_r;
  assign mul_prod = PW'(fac) * PW'(w_r);
  assign addr_sum = prod_r + PW'(off_r);

  // Frame size check
  assign size_prod = PW'(w_r) * PW'(h_r);
  assign size_ok   = (w_r != '0) && (h_r != '0) &&
                     (32'(w_r) <= 32'(MAX_DIM)) && (32'(h_r) <= 32'(MAX_DIM)) &&
                     (32'(size_prod) <= 32'(MAX_PIXELS));

  assign mem_wr_data = rgb_r ? in_tdata : {{(PIX_W-CH_W){1'b0}}, in_tdata[CH_W-1:0]};
  assign drain_pix   = rgb_r ? mem_rd_data : {{(PIX_W-CH_W){1'b0}}, mem_rd_data[CH_W-1:0]};
  assign mem_rd_en   = (state_r == S_ADDR);
  assign div_start   = (state_r == S_START) & valid_r & (drain_cnt_r < total_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    dirty_nxt      = dirty_r;
    total_nxt      = total_r;
    valid_nxt      = valid_r;
    load_cnt_nxt   = load_cnt_r;
    drain_cnt_nxt  = drain_cnt_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (dirty_r) begin
          state_nxt = S_SIZE;
        end else if (in_fire) begin
          out_data_nxt = '0;
          out_last_nxt = 1'b0;
          if (!valid_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_BAD_SIZE;
          end else if (is_load) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = load_full ? ST_LOAD_PAST : ST_OK;
            if (!load_full) begin
              load_cnt_nxt = load_cnt_r + CW'(1);
            end
          end else if (!load_full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EARLY;
          end else begin
            state_nxt = S_ADDR;
            if (last_now) begin
              load_cnt_nxt  = '0;
              drain_cnt_nxt = '0;
              row_nxt       = '0;
              col_nxt       = '0;
            end else begin
              drain_cnt_nxt = k_inc;
              if (col_inc == h_r) begin
                col_nxt = '0;
                row_nxt = row_r + DIM_W'(1);
              end else begin
                col_nxt = col_inc;
              end
            end
          end
        end
      end
      S_ADDR: begin
        state_nxt = S_DATA;
      end
      S_DATA: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = drain_pix;
          out_last_nxt   = last_r;
          state_nxt      = S_IDLE;
        end
      end
      S_SIZE: begin
        valid_nxt = size_ok;
        total_nxt = size_ok ? CW'(size_prod) : '0;
        state_nxt = S_START;
      end
      S_START: begin
        if (div_start) begin
          state_nxt = S_DIV;
        end else begin
          row_nxt   = '0;
          col_nxt   = '0;
          dirty_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          row_nxt   = DIM_W'(div_quot);
          col_nxt   = div_rem;
          dirty_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a register write always forces a recompute, restarting one under way
    if (cfg_fire) begin
      dirty_nxt = 1'b1;
      if ((state_r == S_SIZE) || (state_r == S_START) || (state_r == S_DIV)) begin
        state_nxt = S_SIZE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dirty_r     <= 1'b1;
      total_r     <= '0;
      valid_r     <= 1'b0;
      load_cnt_r  <= '0;
      drain_cnt_r <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      total_r     <= total_nxt;
      valid_r     <= valid_nxt;
      load_cnt_r  <= load_cnt_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= '0;
      h_r   <= '0;
      rgb_r <= 1'b0;
      dir_r <= DIR_CW;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_WIDTH:  w_r   <= cfg_data;
        REG_HEIGHT: h_r   <= cfg_data;
        REG_RGB:    rgb_r <= cfg_data[0];
        REG_DIR:    dir_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Drain datapath and output payload
  always_ff @(posedge clk) begin
    if (drain_ok) begin
      prod_r <= mul_prod;
      off_r  <= off;
      last_r <= last_now;
    end
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  ir90_frame_store #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_ok),
    .wr_addr (AW'(load_cnt_r)),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (AW'(addr_sum)),
    .rd_data (mem_rd_data)
  );

  ir90_divider #(
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (drain_cnt_r),
    .divisor  (h_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

`ifndef SYNTH
  // error beats carry no pixel and never end a frame
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata == '0) && !out_tlast)
    else $error("error beat carries pixel data or last");

  // final drain clears both counters
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    drain_ok && last_now |=> (load_cnt_r == '0) && (drain_cnt_r == '0))
    else $error("counters not cleared after final drain");

  // drain position stays inside the source frame
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !dirty_r |-> (col_r < h_r) && (row_r < w_r))
    else $error("drain position out of frame");

  // a drain read only follows an accepted drain
  a_read_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd_en |-> $past(drain_ok))
    else $error("store read without a drain beat");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ir90_pkg::*;

  localparam int RAND_ITEMS       = 550;
  localparam int SETTLE_CYCLES    = 8;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT      = 3000;
  localparam int N_PLAN           = 38;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } pix_result_t;

  typedef struct packed {
    logic               is_reg;
    logic [CFG_I_W-1:0] reg_idx;
    logic [DIM_W-1:0]   reg_val;
    logic               op;
    logic [PIX_W-1:0]   px;
    logic               typed;
    logic [ST_W-1:0]    st;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [PIX_W-1:0]   in_tdata = '0;   // channel_0, channel_1, channel_2
  logic               in_tuser = OP_LOAD;  // opcode
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [PIX_W-1:0]   out_tdata;       // out_channel_0, out_channel_1, out_channel_2
  logic [ST_W-1:0]    out_tuser;       // status
  logic               out_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_I_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]   cfg_data = '0;

  // Shadow of the engine: registers, counters and frame store
  logic [DIM_W-1:0]   width_reg = '0;
  logic [DIM_W-1:0]   height_reg = '0;
  logic               rgb_reg = 1'b0;
  logic               dir_reg = DIR_CW;
  int unsigned        loaded_px = 0;
  int unsigned        drained_px = 0;
  logic [PIX_W-1:0]   frame_mem [0:DEF_MAX_PIXELS-1];

  pix_result_t        awaited_results [$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  bit                 no_idle = 1'b0;
  bit                 sink_hold_req = 1'b0;

  image_rotate_90 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pixel count of the configured frame, zero when the size is rejected
  function automatic int unsigned frame_pixels();
    int unsigned w;
    int unsigned h;
    w = width_reg;
    h = height_reg;
    if (w == 0 || h == 0 || w > DEF_MAX_DIM || h > DEF_MAX_DIM ||
        w * h > DEF_MAX_PIXELS)
      return 0;
    return w * h;
  endfunction

  // Advance the shadow by one beat and return the result it must produce
  task automatic rotate_step(input logic op, input logic [PIX_W-1:0] px,
                             output pix_result_t res);
    int unsigned total;
    int unsigned w;
    int unsigned h;
    int unsigned k;
    int unsigned r;
    int unsigned c;
    int unsigned idx;
    res = '0;
    total = frame_pixels();
    w = width_reg;
    h = height_reg;
    if (total == 0) begin
      res.status = ST_BAD_SIZE;
    end else if (op == OP_LOAD) begin
      if (loaded_px >= total) begin
        res.status = ST_LOAD_PAST;
      end else begin
        frame_mem[loaded_px] = rgb_reg ? px : {16'h0, px[7:0]};
        loaded_px++;
        res.status = ST_OK;
      end
    end else if (loaded_px < total) begin
      res.status = ST_EARLY;
    end else begin
      // position past the end of a shrunken frame restarts at zero
      k = (drained_px >= total) ? 0 : drained_px;
      r = k / h;
      c = k % h;
      if (dir_reg == DIR_CW)
        idx = (h - 1 - c) * w + r;
      else
        idx = c * w + (w - 1 - r);
      res.pixel = rgb_reg ? frame_mem[idx] : {16'h0, frame_mem[idx][7:0]};
      k++;
      res.last = (k >= total);
      res.status = ST_OK;
      if (res.last) begin
        loaded_px = 0;
        drained_px = 0;
      end else begin
        drained_px = k;
      end
    end
  endtask

  // One input beat; a typed status overrides the shadow's answer
  task automatic send_beat(input logic op, input logic [PIX_W-1:0] px,
                           input bit typed, input logic [ST_W-1:0] typed_st);
    pix_result_t res;
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    rotate_step(op, px, res);
    if (typed)
      res = '{status: typed_st, pixel: '0, last: 1'b0};
    awaited_results.push_back(res);
    @(negedge clk);
  endtask

  // Stop offering beats and let every awaited result come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write; cfg_valid is left high for the caller to drop
  task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  width_reg = val;
      REG_HEIGHT: height_reg = val;
      REG_RGB:    rgb_reg = val[0];
      REG_DIR:    dir_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [DIM_W-1:0] rgb, input logic [DIM_W-1:0] dir);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RGB, rgb);
    write_reg(REG_DIR, dir);
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t reg_row(input logic [CFG_I_W-1:0] idx,
                                        input logic [DIM_W-1:0] val);
    reg_row = '0;
    reg_row.is_reg = 1'b1;
    reg_row.reg_idx = idx;
    reg_row.reg_val = val;
  endfunction

  function automatic plan_row_t beat_row(input logic op, input logic [PIX_W-1:0] px);
    beat_row = '0;
    beat_row.op = op;
    beat_row.px = px;
  endfunction

  function automatic plan_row_t typed_row(input logic op, input logic [PIX_W-1:0] px,
                                          input logic [ST_W-1:0] st);
    typed_row = beat_row(op, px);
    typed_row.typed = 1'b1;
    typed_row.st = st;
  endfunction

  // Result side: random ready bursts, plus one long hold on request
  initial begin : sink_ready
    int n;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 19);
        repeat (n) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest awaited one
  always @(posedge clk) begin : result_check
    pix_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result beat with none awaited: status %0d data %h last %b",
                 $time, out_tuser, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t ns: status expected %0d actual %0d", $time, want.status, out_tuser);
          mismatches++;
        end
        for (int ch = 0; ch < 3; ch++) begin
          if (out_tdata[ch*CH_W +: CH_W] !== want.pixel[ch*CH_W +: CH_W]) begin
            $display("%0t ns: channel %0d expected %h actual %h", $time, ch,
                     want.pixel[ch*CH_W +: CH_W], out_tdata[ch*CH_W +: CH_W]);
            mismatches++;
          end
        end
        if (out_tlast !== want.last) begin
          $display("%0t ns: last expected %b actual %b", $time, want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no beat accepted for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t          directed_plan [0:N_PLAN-1];
    bit                 in_reg_group;
    int                 phase;
    int                 budget;
    int                 rand_items;
    int                 pick;
    int unsigned        total;
    logic               op;
    logic [DIM_W-1:0]   fw;
    logic [DIM_W-1:0]   fh;

    directed_plan = '{
      // reset sizes are zero
      typed_row(OP_LOAD, 24'h000000, ST_BAD_SIZE),
      typed_row(OP_DRAIN, 24'hFFFFFF, ST_BAD_SIZE),
      // width just over the limit
      reg_row(REG_WIDTH, 11'd1025),
      reg_row(REG_HEIGHT, 11'd1),
      typed_row(OP_LOAD, 24'h5A5A5A, ST_BAD_SIZE),
      // all-ones sizes
      reg_row(REG_WIDTH, 11'd2047),
      reg_row(REG_HEIGHT, 11'd2047),
      typed_row(OP_DRAIN, 24'hA5A5A5, ST_BAD_SIZE),
      // legal dimensions, product over capacity
      reg_row(REG_WIDTH, 11'd1024),
      reg_row(REG_HEIGHT, 11'd65),
      typed_row(OP_LOAD, 24'h010203, ST_BAD_SIZE),
      // zero height
      reg_row(REG_WIDTH, 11'd1),
      reg_row(REG_HEIGHT, 11'd0),
      typed_row(OP_LOAD, 24'h0F0F0F, ST_BAD_SIZE),
      // 2x2 color, clockwise: early drain, full load, load past the frame
      reg_row(REG_WIDTH, 11'd2),
      reg_row(REG_HEIGHT, 11'd2),
      reg_row(REG_RGB, 11'd1),
      reg_row(REG_DIR, 11'(DIR_CW)),
      typed_row(OP_DRAIN, 24'hFFFFFF, ST_EARLY),
      typed_row(OP_LOAD, 24'hFFFFFF, ST_OK),
      typed_row(OP_LOAD, 24'h000000, ST_OK),
      typed_row(OP_LOAD, 24'hA55AC3, ST_OK),
      typed_row(OP_LOAD, 24'h3C0F81, ST_OK),
      typed_row(OP_LOAD, 24'h123456, ST_LOAD_PAST),
      beat_row(OP_DRAIN, 24'h000000),
      beat_row(OP_DRAIN, 24'hFFFFFF),
      beat_row(OP_DRAIN, 24'h000000),
      beat_row(OP_DRAIN, 24'hFFFFFF),
      // grey, counter-clockwise via upper data bits, 3x1
      reg_row(REG_RGB, 11'h7FE),
      reg_row(REG_DIR, 11'h7FF),
      reg_row(REG_WIDTH, 11'd3),
      reg_row(REG_HEIGHT, 11'd1),
      typed_row(OP_LOAD, 24'hFF807F, ST_OK),
      typed_row(OP_LOAD, 24'h010203, ST_OK),
      typed_row(OP_LOAD, 24'hABCDEF, ST_OK),
      beat_row(OP_DRAIN, 24'h000000),
      beat_row(OP_DRAIN, 24'h000000),
      beat_row(OP_DRAIN, 24'h000000)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    in_reg_group = 1'b0;
    for (int i = 0; i < N_PLAN; i++) begin
      if (directed_plan[i].is_reg) begin
        if (!in_reg_group)
          wait_idle();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
        in_reg_group = 1'b1;
      end else begin
        if (in_reg_group)
          cfg_valid <= 1'b0;
        in_reg_group = 1'b0;
        send_beat(directed_plan[i].op, directed_plan[i].px, directed_plan[i].typed,
                  directed_plan[i].st);
      end
    end

    // Widest frame, partial clockwise drain, then shrink so the drain
    // position lands outside the frame
    set_frame(11'd1024, 11'd1, 11'd1, 11'(DIR_CW));
    repeat (1024) send_beat(OP_LOAD, 24'($urandom), 1'b0, ST_OK);
    repeat (100) send_beat(OP_DRAIN, 24'($urandom), 1'b0, ST_OK);
    set_frame(11'd2, 11'd2, 11'd1, 11'(DIR_CCW));
    repeat (4) send_beat(OP_DRAIN, 24'($urandom), 1'b0, ST_OK);

    // Tall frame in grey, direction flipped mid-drain, then shrink to 1x1
    set_frame(11'd1, 11'd64, 11'd0, 11'(DIR_CCW));
    repeat (64) send_beat(OP_LOAD, 24'($urandom), 1'b0, ST_OK);
    repeat (20) send_beat(OP_DRAIN, 24'($urandom), 1'b0, ST_OK);
    set_frame(11'd1, 11'd64, 11'd0, 11'(DIR_CW));
    repeat (20) send_beat(OP_DRAIN, 24'($urandom), 1'b0, ST_OK);
    set_frame(11'd1, 11'd1, 11'd0, 11'(DIR_CW));
    send_beat(OP_DRAIN, 24'($urandom), 1'b0, ST_OK);

    // Random frames: mostly well-formed load/drain runs with some noise;
    // frames may be cut short so the next size meets stale counters
    phase = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      phase++;
      if (rand_items > RAND_ITEMS * 85 / 100)
        no_idle = 1'b1;
      pick = $urandom_range(0, 9);
      if (phase == 3) begin
        fw = 11'd8;
        fh = 11'd8;
      end else if (pick == 0) begin
        fw = 11'($urandom_range(0, 2047));
        fh = 11'($urandom_range(0, 2047));
      end else if (pick == 1) begin
        fw = 11'($urandom_range(1, 40));
        fh = 11'($urandom_range(1, 4));
      end else begin
        fw = 11'($urandom_range(1, 6));
        fh = 11'($urandom_range(1, 6));
      end
      set_frame(fw, fh, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
      // long result-side hold while loads keep coming
      if (phase == 3)
        sink_hold_req = 1'b1;
      total = frame_pixels();
      if (total == 0) begin
        budget = $urandom_range(3, 8);
      end else begin
        budget = 2 * total * $urandom_range(1, 2) + $urandom_range(0, 3);
        if ($urandom_range(0, 4) == 0)
          budget = $urandom_range(1, 2 * total);
      end
      if (budget > RAND_ITEMS - rand_items)
        budget = RAND_ITEMS - rand_items;
      repeat (budget) begin
        if ($urandom_range(0, 9) == 0)
          op = 1'($urandom_range(0, 1));
        else
          op = (loaded_px < total) ? OP_LOAD : OP_DRAIN;
        send_beat(op, 24'($urandom), 1'b0, ST_OK);
        rand_items++;
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
